>>> rtl/dmae_pkg.sv
// ----------------------------------------------------------------------------
// DMA address engine package
// Transaction types, operation codes, mode codes and shared helper functions
// for the four-channel DMA address engine.
// ----------------------------------------------------------------------------
package dmae_pkg;

   // Operation codes carried in the action field of a request.
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_SHADOW  = 2'd1;
   localparam logic [1:0] ACT_CONTROL = 2'd2;

   // Address step modes (destination in mode bits 1:0, source in 3:2).
   localparam logic [1:0] MODE_INC        = 2'd0;
   localparam logic [1:0] MODE_DEC        = 2'd1;
   localparam logic [1:0] MODE_FIXED      = 2'd2;
   localparam logic [1:0] MODE_INC_RELOAD = 2'd3;

   // Start timing codes (mode bits 8:7).
   localparam logic [1:0] TIMING_NOW     = 2'd0;
   localparam logic [1:0] TIMING_VBLANK  = 2'd1;
   localparam logic [1:0] TIMING_HBLANK  = 2'd2;
   localparam logic [1:0] TIMING_SPECIAL = 2'd3;

   // Control word layout.
   localparam int CTL_ENABLE_BIT = 15;
   localparam int MODE_W         = 11;

   // Bit positions inside the latched mode bits.
   localparam int MODE_REPEAT_BIT = 4;
   localparam int MODE_WORD_BIT   = 5;
   localparam int MODE_IRQ_BIT    = 9;

   // Address masks and full-length counts.
   localparam int ADDR_W = 28;
   localparam int UNIT_W = 17;
   localparam logic [ADDR_W-1:0] ADDR_MASK_WIDE   = 28'hfffffff;
   localparam logic [ADDR_W-1:0] ADDR_MASK_NARROW = 28'h7ffffff;
   localparam logic [UNIT_W-1:0] FULL_COUNT_WIDE   = 17'h10000;
   localparam logic [UNIT_W-1:0] FULL_COUNT_NARROW = 17'h04000;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  channel;
      logic [15:0] control_value;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] unit_count;
      logic        vblank_flag;
      logic        hblank_flag;
   } req_type;

   typedef struct packed {
      logic        transfer_valid;
      logic [1:0]  active_channel;
      logic [31:0] read_address;
      logic [31:0] write_address;
      logic        word_mode;
      logic [3:0]  irq_mask;
   } rsp_type;

   // Per-channel strobes, already qualified by the pipeline advance.
   typedef struct packed {
      logic tick;
      logic wr_shadow;
      logic wr_ctl;
   } chan_cmd_type;

   // Per-channel status toward the arbiter and result builder.
   typedef struct packed {
      logic run_eff;
      logic word;
      logic irq;
      logic armed;
      logic running;
   } chan_stat_type;

   // A zero count stands for the largest transfer of the channel.
   function automatic logic [UNIT_W-1:0] full_count(input logic [15:0] cnt,
                                                    input logic        wide);
      logic [UNIT_W-1:0] res;
      if (cnt == 16'd0) begin
         res = wide ? FULL_COUNT_WIDE : FULL_COUNT_NARROW;
      end else begin
         res = {1'b0, cnt};
      end
      return res;
   endfunction

   function automatic logic [31:0] step_offset(input logic [31:0] off,
                                               input logic [1:0]  mode,
                                               input logic        word);
      logic [31:0] size;
      logic [31:0] res;
      size = word ? 32'd4 : 32'd2;
      case (mode)
         MODE_DEC:   res = off - size;
         MODE_FIXED: res = off;
         default:    res = off + size;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/dmae_chan.sv
// ----------------------------------------------------------------------------
// DMA address engine channel
// Shadow registers, armed copy, offsets and unit counter of one channel.
// ----------------------------------------------------------------------------
module dmae_chan import dmae_pkg::*; #(
   parameter int CHAN_ID = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  chan_cmd_type  cmd,
   input  logic          grant,
   input  req_type       req,
   output chan_stat_type stat,
   output logic [31:0]   read_addr,
   output logic [31:0]   write_addr
);

   localparam logic IS_WIDE = (CHAN_ID == 3);
   localparam logic [ADDR_W-1:0] MASK = IS_WIDE ? ADDR_MASK_WIDE : ADDR_MASK_NARROW;

   logic [31:0]       shadow_src_ff, shadow_src_in;
   logic [31:0]       shadow_dst_ff, shadow_dst_in;
   logic [15:0]       shadow_cnt_ff, shadow_cnt_in;
   logic [ADDR_W-1:0] base_src_ff, base_src_in;
   logic [ADDR_W-1:0] base_dst_ff, base_dst_in;
   logic [UNIT_W-1:0] target_ff, target_in;
   logic [UNIT_W-1:0] done_ff, done_in;
   logic [31:0]       src_off_ff, src_off_in;
   logic [31:0]       dst_off_ff, dst_off_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              armed_ff, armed_in;
   logic              running_ff, running_in;

   logic              go_start;
   logic              run_eff;
   logic [31:0]       src_eff;
   logic [31:0]       dst_eff;
   logic [UNIT_W-1:0] done_eff;
   logic [UNIT_W-1:0] done_next;
   logic              last_unit;
   logic [1:0]        timing;

   assign timing   = mode_ff[8:7];
   assign go_start = armed_ff && !running_ff &&
                     ((timing == TIMING_NOW) ||
                      (timing == TIMING_VBLANK && req.vblank_flag) ||
                      (timing == TIMING_HBLANK && req.hblank_flag));
   assign run_eff   = running_ff || go_start;
   assign src_eff   = go_start ? '0 : src_off_ff;
   assign dst_eff   = go_start ? '0 : dst_off_ff;
   assign done_eff  = go_start ? '0 : done_ff;
   assign done_next = done_eff + UNIT_W'(1);
   assign last_unit = (done_next == target_ff);

   assign read_addr  = {{(32-ADDR_W){1'b0}}, base_src_ff} + src_eff;
   assign write_addr = {{(32-ADDR_W){1'b0}}, base_dst_ff} + dst_eff;

   assign stat.run_eff = run_eff;
   assign stat.word    = mode_ff[MODE_WORD_BIT];
   assign stat.irq     = last_unit && mode_ff[MODE_IRQ_BIT];
   assign stat.armed   = armed_ff;
   assign stat.running = running_ff;

   always_comb begin
      shadow_src_in = shadow_src_ff;
      shadow_dst_in = shadow_dst_ff;
      shadow_cnt_in = shadow_cnt_ff;
      base_src_in   = base_src_ff;
      base_dst_in   = base_dst_ff;
      target_in     = target_ff;
      done_in       = done_ff;
      src_off_in    = src_off_ff;
      dst_off_in    = dst_off_ff;
      mode_in       = mode_ff;
      armed_in      = armed_ff;
      running_in    = running_ff;

      if (cmd.wr_shadow) begin
         shadow_src_in = req.source_address;
         shadow_dst_in = req.dest_address;
         shadow_cnt_in = req.unit_count;
      end

      if (cmd.wr_ctl && !armed_ff && req.control_value[CTL_ENABLE_BIT]) begin
         base_src_in = shadow_src_ff[ADDR_W-1:0] & MASK;
         base_dst_in = shadow_dst_ff[ADDR_W-1:0] & MASK;
         target_in   = full_count(shadow_cnt_ff, IS_WIDE);
         mode_in     = req.control_value[15:5];
         armed_in    = 1'b1;
      end

      if (cmd.tick) begin
         if (grant) begin
            done_in    = done_next;
            dst_off_in = step_offset(dst_eff, mode_ff[1:0], mode_ff[MODE_WORD_BIT]);
            src_off_in = step_offset(src_eff, mode_ff[3:2], mode_ff[MODE_WORD_BIT]);
            running_in = 1'b1;
            if (last_unit) begin
               running_in = 1'b0;
               if (mode_ff[MODE_REPEAT_BIT]) begin
                  target_in = full_count(shadow_cnt_ff, IS_WIDE);
                  if (mode_ff[1:0] == MODE_INC_RELOAD) begin
                     base_dst_in = shadow_dst_ff[ADDR_W-1:0] & MASK;
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end else begin
            running_in = run_eff;
            src_off_in = src_eff;
            dst_off_in = dst_eff;
            done_in    = done_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_src_ff <= '0;
         shadow_dst_ff <= '0;
         shadow_cnt_ff <= '0;
         base_src_ff   <= '0;
         base_dst_ff   <= '0;
         target_ff     <= '0;
         done_ff       <= '0;
         src_off_ff    <= '0;
         dst_off_ff    <= '0;
         mode_ff       <= '0;
         armed_ff      <= 1'b0;
         running_ff    <= 1'b0;
      end else begin
         shadow_src_ff <= shadow_src_in;
         shadow_dst_ff <= shadow_dst_in;
         shadow_cnt_ff <= shadow_cnt_in;
         base_src_ff   <= base_src_in;
         base_dst_ff   <= base_dst_in;
         target_ff     <= target_in;
         done_ff       <= done_in;
         src_off_ff    <= src_off_in;
         dst_off_ff    <= dst_off_in;
         mode_ff       <= mode_in;
         armed_ff      <= armed_in;
         running_ff    <= running_in;
      end
   end

endmodule

>>> rtl/four_channel_dma_address_engine.sv
// ----------------------------------------------------------------------------
// Four-channel DMA address engine
// Register-write front end, start timing, fixed-priority arbitration and
// address generation for a small multi-channel DMA controller.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_data) carries one transaction
// per operation: a tick, a shadow write (source, destination, count) or a
// control write for the channel named in the transaction. Every request
// transaction produces exactly one response transaction on the rsp_ channel.
// A tick response reports the transfer issued by the lowest-numbered running
// channel, or all zeros when no channel runs; write responses are all zeros.
// A transaction accepted into the input register has its response registered
// in the output register as soon as the output register can take it.
// Throughput is one transaction per cycle while the receiver does not stall;
// the path between the two registers is the channel start check, the
// priority pick and two 32-bit address adds per channel.
// When the receiver stalls, the response holds in the output register and one
// more request is still taken into the input register; req_stall then rises
// until the response is taken. Synchronous reset clears all channel state
// (shadows, bases, counts, armed and running flags) and empties both registers.
// ----------------------------------------------------------------------------
module four_channel_dma_address_engine import dmae_pkg::*; #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register holding the transaction being worked on.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;

   // Output register holding the finished response.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // The input register moves into the output register whenever the output
   // register is empty or is being emptied in this cycle.
   logic advance;

   chan_cmd_type             cmd   [NUM_CHANNELS];
   chan_stat_type            stat  [NUM_CHANNELS];
   logic [31:0]              rd_addr [NUM_CHANNELS];
   logic [31:0]              wr_addr [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]  grant;
   logic [NUM_CHANNELS-1:0]  run_vec;
   logic [NUM_CHANNELS-1:0]  arm_vec;
   logic                     is_tick;
   rsp_type                  result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign is_tick   = (s1_data_ff.action == ACT_TICK);

   // Each channel sees strobes only when the transaction actually advances;
   // writes are steered by the channel field.
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      always_comb begin
         cmd[g].tick      = advance && is_tick;
         cmd[g].wr_shadow = advance && (s1_data_ff.action == ACT_SHADOW) &&
                            (32'(s1_data_ff.channel) == g);
         cmd[g].wr_ctl    = advance && (s1_data_ff.action == ACT_CONTROL) &&
                            (32'(s1_data_ff.channel) == g);
      end

      dmae_chan #(
         .CHAN_ID (g)
      ) u_chan (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[g]),
         .grant      (grant[g]),
         .req        (s1_data_ff),
         .stat       (stat[g]),
         .read_addr  (rd_addr[g]),
         .write_addr (wr_addr[g])
      );

      assign run_vec[g] = stat[g].running;
      assign arm_vec[g] = stat[g].armed;
   end

   // Fixed priority: the lowest-numbered channel that runs after this tick's
   // start check wins the transfer.
   always_comb begin
      logic taken;
      taken = 1'b0;
      grant = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         grant[i] = is_tick && stat[i].run_eff && !taken;
         taken    = taken || stat[i].run_eff;
      end
   end

   // Build the response. Only the granted channel contributes, so an OR over
   // the channels is the selection; irq bits above channel three are dropped.
   always_comb begin
      result = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (grant[i]) begin
            result.transfer_valid = 1'b1;
            result.active_channel = 2'(i);
            result.read_address   = rd_addr[i];
            result.write_address  = wr_addr[i];
            result.word_mode      = stat[i].word;
            if (i < 4) begin
               result.irq_mask[2'(i)] = stat[i].irq;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // At most one channel may be granted the bus on a tick.
   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant))
      else $error("more than one channel granted");

   // A channel can only be running while it is armed.
   a_run_armed: assert property (@(posedge clock) disable iff (reset)
      (run_vec & ~arm_vec) == '0)
      else $error("channel running without being armed");

   // Register and control writes never produce a transfer.
   a_write_no_xfer: assert property (@(posedge clock) disable iff (reset)
      advance && !is_tick |=> rsp_valid && !rsp_data.transfer_valid)
      else $error("write transaction produced a transfer");

   // An idle response carries no interrupt request and no channel number.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.transfer_valid |->
         rsp_data.irq_mask == 4'd0 && rsp_data.active_channel == 2'd0)
      else $error("idle response carries stray fields");

   // The input side is held back only behind a stalled, full output register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");
`endif

endmodule

>>> sim/four_channel_dma_address_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-channel DMA address engine testbench
// Drives ticks, shadow writes and control writes into the engine with random
// idling on both channels, keeps its own model of every channel's registers,
// and checks each response transaction field by field against the expected
// transfer.
// ----------------------------------------------------------------------------

import dmae_pkg::*;

class dma_transfer_board;

   rsp_type     pending_transfers[$];
   int unsigned error_count;

   logic [31:0]        shadow_source[4];
   logic [31:0]        shadow_dest[4];
   logic [15:0]        shadow_count[4];
   logic [ADDR_W-1:0]  base_source[4];
   logic [ADDR_W-1:0]  base_dest[4];
   logic [UNIT_W-1:0]  target_units[4];
   logic [UNIT_W-1:0]  done_units[4];
   logic [31:0]        source_offset[4];
   logic [31:0]        dest_offset[4];
   logic [MODE_W-1:0]  mode_bits[4];
   bit                 armed[4];
   bit                 running[4];

   function new();
      error_count = 0;
      for (int i = 0; i < 4; i++) begin
         shadow_source[i] = '0;
         shadow_dest[i]   = '0;
         shadow_count[i]  = '0;
         base_source[i]   = '0;
         base_dest[i]     = '0;
         target_units[i]  = '0;
         done_units[i]    = '0;
         source_offset[i] = '0;
         dest_offset[i]   = '0;
         mode_bits[i]     = '0;
         armed[i]         = 0;
         running[i]       = 0;
      end
   endfunction

   // Channel 3 reaches 28 address bits, the others 27.
   function logic [ADDR_W-1:0] channel_mask(int unsigned ch);
      return (ch == 3) ? 28'hfffffff : 28'h7ffffff;
   endfunction

   function logic [UNIT_W-1:0] length_of(int unsigned ch, logic [15:0] cnt);
      if (cnt != 16'd0) begin
         return {1'b0, cnt};
      end
      return (ch == 3) ? 17'h10000 : 17'h04000;
   endfunction

   function logic [31:0] advance(logic [31:0] off, logic [1:0] mode, logic word);
      logic [31:0] size;
      size = word ? 32'd4 : 32'd2;
      if (mode == MODE_DEC) begin
         return off - size;
      end else if (mode == MODE_FIXED) begin
         return off;
      end
      return off + size;
   endfunction

   function rsp_type predict_transfer(req_type r);
      rsp_type           res;
      int unsigned       ch;
      logic [1:0]        timing;
      logic [MODE_W-1:0] m;
      logic              word;
      bit                found;
      res   = '0;
      found = 0;
      ch    = int'(r.channel);
      case (r.action)
         ACT_SHADOW: begin
            shadow_source[ch] = r.source_address;
            shadow_dest[ch]   = r.dest_address;
            shadow_count[ch]  = r.unit_count;
         end
         ACT_CONTROL: begin
            // Only an idle channel with the enable bit set latches anything.
            if (!armed[ch] && r.control_value[CTL_ENABLE_BIT]) begin
               base_source[ch]  = shadow_source[ch][ADDR_W-1:0] & channel_mask(ch);
               base_dest[ch]    = shadow_dest[ch][ADDR_W-1:0] & channel_mask(ch);
               target_units[ch] = length_of(ch, shadow_count[ch]);
               mode_bits[ch]    = r.control_value[15:5];
               armed[ch]        = 1;
            end
         end
         ACT_TICK: begin
            for (int i = 0; i < 4; i++) begin
               if (armed[i] && !running[i]) begin
                  timing = mode_bits[i][8:7];
                  if (timing == TIMING_NOW ||
                      (timing == TIMING_VBLANK && r.vblank_flag) ||
                      (timing == TIMING_HBLANK && r.hblank_flag)) begin
                     running[i]       = 1;
                     source_offset[i] = '0;
                     dest_offset[i]   = '0;
                     done_units[i]    = '0;
                  end
               end
            end
            for (int i = 0; i < 4; i++) begin
               if (!found && running[i]) begin
                  found = 1;
                  m     = mode_bits[i];
                  word  = m[MODE_WORD_BIT];
                  res.transfer_valid = 1'b1;
                  res.active_channel = 2'(i);
                  res.read_address   = {4'd0, base_source[i]} + source_offset[i];
                  res.write_address  = {4'd0, base_dest[i]} + dest_offset[i];
                  res.word_mode      = word;
                  done_units[i]    = done_units[i] + 17'd1;
                  dest_offset[i]   = advance(dest_offset[i], m[1:0], word);
                  source_offset[i] = advance(source_offset[i], m[3:2], word);
                  if (done_units[i] == target_units[i]) begin
                     if (m[MODE_REPEAT_BIT]) begin
                        target_units[i] = length_of(i, shadow_count[i]);
                        if (m[1:0] == MODE_INC_RELOAD) begin
                           base_dest[i] = shadow_dest[i][ADDR_W-1:0] & channel_mask(i);
                        end
                     end else begin
                        armed[i] = 0;
                     end
                     running[i] = 0;
                     if (m[MODE_IRQ_BIT]) begin
                        res.irq_mask[i] = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function void note_request(req_type r);
      pending_transfers.push_back(predict_transfer(r));
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending_transfers.size() == 0) begin
         error_count++;
         if (error_count <= 10) begin
            $display("unexpected response: valid=%0d ch=%0d rd=%h wr=%h word=%0d irq=%h",
                     got.transfer_valid, got.active_channel, got.read_address,
                     got.write_address, got.word_mode, got.irq_mask);
         end
         return;
      end
      want = pending_transfers.pop_front();
      if (got.transfer_valid !== want.transfer_valid ||
          got.active_channel !== want.active_channel ||
          got.read_address !== want.read_address ||
          got.write_address !== want.write_address ||
          got.word_mode !== want.word_mode ||
          got.irq_mask !== want.irq_mask) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch expected: valid=%0d ch=%0d rd=%h wr=%h word=%0d irq=%h",
                     want.transfer_valid, want.active_channel, want.read_address,
                     want.write_address, want.word_mode, want.irq_mask);
            $display("         actual:   valid=%0d ch=%0d rd=%h wr=%h word=%0d irq=%h",
                     got.transfer_valid, got.active_channel, got.read_address,
                     got.write_address, got.word_mode, got.irq_mask);
         end
      end
   endfunction

endclass

module four_channel_dma_address_engine_test;

   localparam int CHANNELS     = 4;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   // Control word fields as seen from the bus side. The mode bits start at
   // bit 5, so the latched mode bit positions are shifted up by five.
   localparam int CTL_MODE_LSB   = 5;
   localparam int CTL_DEST_LSB   = 5;
   localparam int CTL_SRC_LSB    = 7;
   localparam int CTL_REPEAT_BIT = CTL_MODE_LSB + MODE_REPEAT_BIT;
   localparam int CTL_WORD_BIT   = CTL_MODE_LSB + MODE_WORD_BIT;
   localparam int CTL_TIMING_LSB = 12;
   localparam int CTL_IRQ_BIT    = CTL_MODE_LSB + MODE_IRQ_BIT;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Pacing controls. calm_* gives stretches with no idling on that side; rush
   // forces back-to-back traffic for the long full-length transfers.
   bit          calm_requests  = 0;
   bit          calm_responses = 0;
   bit          rush           = 0;
   int unsigned items_sent     = 0;
   int unsigned quiet_cycles   = 0;

   dma_transfer_board board = new();

   four_channel_dma_address_engine #(
      .NUM_CHANNELS(CHANNELS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Both channels are observed here, at the edge itself, so the values seen
   // are the ones the engine sampled. A transaction that was accepted goes to
   // the model; a response that was accepted is checked against the oldest
   // expected transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            board.check_response(rsp_data);
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            board.note_request(req_data);
         end
      end
   end

   // The watchdog counts edges at which neither channel moved a transaction.
   // The longest legal pause is a full request gap plus a full response stall
   // plus the passage through both registers, well under the limit.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver holds stall for a random number of cycles before each
   // response, then takes exactly one response and draws again.
   initial begin : response_pacing
      int unsigned hold;
      int unsigned taken;
      taken = 0;
      forever begin
         if (taken % 50 == 0) begin
            calm_responses = ($urandom_range(0, 3) == 0);
         end
         hold = (rush || calm_responses) ? 0 : $urandom_range(0, 15);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset !== 1'b0 || rsp_valid !== 1'b1);
         taken++;
      end
   end

   // Presents one transaction after a random gap and waits until the engine
   // takes it. With no gap valid simply stays high into the next transaction.
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = (rush || calm_requests) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   // Fields that an operation does not use still carry random values, so the
   // engine has to ignore them.
   function automatic req_type junk_request();
      logic [127:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   task automatic send_shadow(input int unsigned ch, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] cnt);
      req_type r;
      r = junk_request();
      r.action         = ACT_SHADOW;
      r.channel        = 2'(ch);
      r.source_address = src;
      r.dest_address   = dst;
      r.unit_count     = cnt;
      send_request(r);
   endtask

   task automatic send_control(input int unsigned ch, input logic [15:0] ctl);
      req_type r;
      r = junk_request();
      r.action        = ACT_CONTROL;
      r.channel       = 2'(ch);
      r.control_value = ctl;
      send_request(r);
   endtask

   task automatic send_tick(input logic vblank, input logic hblank);
      req_type r;
      r = junk_request();
      r.action      = ACT_TICK;
      r.vblank_flag = vblank;
      r.hblank_flag = hblank;
      send_request(r);
   endtask

   function automatic logic [15:0] make_control(input logic [1:0] dst_mode,
                                                input logic [1:0] src_mode,
                                                input logic rep, input logic word,
                                                input logic [1:0] timing,
                                                input logic irq, input logic en);
      logic [15:0] ctl;
      ctl = '0;
      ctl[CTL_DEST_LSB +: 2]   = dst_mode;
      ctl[CTL_SRC_LSB +: 2]    = src_mode;
      ctl[CTL_REPEAT_BIT]      = rep;
      ctl[CTL_WORD_BIT]        = word;
      ctl[CTL_TIMING_LSB +: 2] = timing;
      ctl[CTL_IRQ_BIT]         = irq;
      ctl[CTL_ENABLE_BIT]      = en;
      return ctl;
   endfunction

   // A random control word that can never lock a channel for good: no repeat
   // and no special timing. The enable bit is mostly set.
   function automatic logic [15:0] one_shot_control();
      logic [15:0] ctl;
      ctl = 16'($urandom);
      ctl[CTL_REPEAT_BIT]      = 1'b0;
      ctl[CTL_TIMING_LSB +: 2] = 2'($urandom_range(0, 2));
      ctl[CTL_ENABLE_BIT]      = ($urandom_range(0, 9) != 0);
      return ctl;
   endfunction

   // Random traffic. Most of it is well-formed programming sequences (shadow
   // write, control write) and bursts of ticks to run them; the rest is
   // unknown actions and stray control writes. A shadow write with a fully
   // random count is always overwritten by one with a short count before any
   // tick, so no channel ever latches or reloads a long count here.
   task automatic run_random(input int unsigned count, input bit repeat_phase);
      int unsigned goal;
      int unsigned pick;
      int unsigned ch;
      int unsigned burst;
      int unsigned flag_odds;
      req_type     r;
      goal      = items_sent + count;
      flag_odds = repeat_phase ? 3 : 1;
      while (items_sent < goal) begin
         if ($urandom_range(0, 63) == 0) begin
            calm_requests = ($urandom_range(0, 2) == 0);
         end
         pick = $urandom_range(0, 99);
         ch   = $urandom_range(0, CHANNELS - 1);
         if (pick < 35) begin
            if ($urandom_range(0, 4) == 0) begin
               send_shadow(ch, $urandom, $urandom, 16'($urandom));
            end
            send_shadow(ch, $urandom, $urandom, 16'($urandom_range(1, 6)));
            if (!repeat_phase) begin
               send_control(ch, one_shot_control());
            end
         end else if (pick < 88) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               send_tick($urandom_range(0, flag_odds) == 0,
                         $urandom_range(0, flag_odds) == 0);
            end
         end else if (pick < 93) begin
            r = junk_request();
            r.action = 2'd3;
            send_request(r);
         end else begin
            send_control(ch, one_shot_control());
         end
      end
   endtask

   initial begin : stimulus
      int unsigned timing_a;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Channel 0 with all-ones addresses: both masked to 27
      // bits, decrementing 32-bit destination, fixed source, interrupt on the
      // second unit.
      send_shadow(0, 32'hffffffff, 32'hffffffff, 16'd2);
      send_control(0, make_control(MODE_DEC, MODE_FIXED, 1'b0, 1'b1, TIMING_NOW,
                                   1'b1, 1'b1));
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      // Channel 3 keeps 28 address bits and waits for vertical blank; the
      // horizontal flag alone must not start it.
      send_shadow(3, 32'hffffffff, 32'hf0000000, 16'd1);
      send_control(3, make_control(MODE_INC_RELOAD, MODE_DEC, 1'b0, 1'b0,
                                   TIMING_VBLANK, 1'b1, 1'b1));
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      // A write without the enable bit is dropped, and so is a second control
      // write to a channel that is already armed.
      send_shadow(1, 32'h00000000, 32'h00000000, 16'hffff);
      send_shadow(1, 32'h00000000, 32'h00000000, 16'd1);
      send_control(1, make_control(MODE_INC, MODE_INC, 1'b0, 1'b0, TIMING_NOW,
                                   1'b0, 1'b0));
      send_tick(1'b1, 1'b1);
      send_control(1, make_control(MODE_INC, MODE_INC, 1'b0, 1'b0, TIMING_HBLANK,
                                   1'b0, 1'b1));
      send_control(1, make_control(MODE_FIXED, MODE_FIXED, 1'b0, 1'b1, TIMING_NOW,
                                   1'b1, 1'b1));
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      // Unknown action with every field at its top value.
      send_request('1);
      // Two channels at once: channel 0 wins the priority pick first, then
      // channel 2 runs its three units with an incrementing source in mode 3.
      send_shadow(2, 32'h12345678, 32'h87654321, 16'd3);
      send_control(2, make_control(MODE_INC, MODE_INC_RELOAD, 1'b0, 1'b0, TIMING_NOW,
                                   1'b1, 1'b1));
      send_shadow(0, 32'h00000000, 32'h00000000, 16'd1);
      send_control(0, make_control(MODE_INC, MODE_INC, 1'b0, 1'b1, TIMING_NOW,
                                   1'b0, 1'b1));
      repeat (4) send_tick(1'b0, 1'b0);

      run_random(1250, 1'b0);

      // Both flags on every tick start everything still armed, and short
      // counts on four channels finish well within this many ticks.
      repeat (30) send_tick(1'b1, 1'b1);

      // Repeat phase. These channels stay armed for the rest of the run, so it
      // comes last. Channels 0 and 1 restart on the two blank flags, channel 3
      // restarts at once, and channel 2 takes the all-ones control word, which
      // selects special timing and never starts.
      timing_a = $urandom_range(1, 2);
      send_shadow(0, $urandom, $urandom, 16'($urandom_range(1, 6)));
      send_control(0, make_control(2'($urandom), 2'($urandom), 1'b1, 1'($urandom),
                                   2'(timing_a), 1'($urandom), 1'b1));
      send_shadow(1, $urandom, $urandom, 16'($urandom_range(1, 6)));
      send_control(1, make_control(2'($urandom), 2'($urandom), 1'b1, 1'($urandom),
                                   2'(3 - timing_a), 1'($urandom), 1'b1));
      send_shadow(3, $urandom, $urandom, 16'($urandom_range(1, 6)));
      send_control(3, make_control(MODE_INC_RELOAD, 2'($urandom), 1'b1, 1'($urandom),
                                   TIMING_NOW, 1'b1, 1'b1));
      send_shadow(2, $urandom, $urandom, 16'd1);
      send_control(2, 16'hffff);
      run_random(300, 1'b1);

      // Zero counts. Channel 3 reloads the full 0x10000 units on its next
      // repeat; with no blank flags the other channels stop and it gets the
      // ticks. Then channel 0 reloads the full 0x4000 units and takes over the
      // bus. Neither long run finishes before the end of the test. Traffic is
      // back to back on both sides here.
      rush = 1;
      send_shadow(3, $urandom, $urandom, 16'd0);
      repeat (20) send_tick(1'b0, 1'b0);
      send_shadow(0, $urandom, $urandom, 16'd0);
      repeat (20) send_tick(1'b1, 1'b1);
      rush = 0;

      req_valid <= 1'b0;
      while (board.pending_transfers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.error_count == 0 && board.pending_transfers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
